### sv/ilid_pkg.sv
// Shared types and constants for the indexed list insert/delete unit.
// No dependencies; imported by the cell, the top level and the checker.
package ilid_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int CNT_OUT_W    = 7;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [2:0] {
        ACT_READ   = 3'd0,
        ACT_FRONT  = 3'd1,
        ACT_BACK   = 3'd2,
        ACT_AT     = 3'd3,
        ACT_DELETE = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command broadcast to every cell of the row; only legal actions arrive here.
    typedef struct packed {
        logic ins;
        logic del;
        logic rd;
    } cell_cmd_t;

endpackage

### sv/indexed_list_insert_delete_unit.sv
// Indexed list insert/delete unit: every command word yields one result word.
// An accepted word moves the control to S_RESP; leaving S_RESP raises done and loads the result word.
// A new command is refused while busy; busy covers the cycle in which the selected
// slot drives the read bus into the result register.
// The receiver cannot stall; results are shown for exactly one cycle.
// Reset clears the length and control; slot contents stay undefined until written.
module indexed_list_insert_delete_unit #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     action,
    input  logic [ilid_pkg::POS_W-1:0]     position,
    input  logic signed [ilid_pkg::DATA_W-1:0] value,
    output logic                           done,
    output logic signed [ilid_pkg::DATA_W-1:0] read_value,
    output logic [1:0]                     status,
    output logic [ilid_pkg::CNT_OUT_W-1:0] entry_count
);
    import ilid_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CW > POS_W) ? CW : POS_W;
    localparam logic [AW-1:0] CAP_A = AW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_RESP
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    status_t                st_reg;
    status_t                st_next;
    logic                   rd_ok_reg;
    logic                   rd_ok_next;
    logic                   done_reg;
    logic [DATA_W-1:0]      read_value_reg;
    logic [1:0]             status_reg;
    logic [CNT_OUT_W-1:0]   entry_count_reg;

    logic                   accept;
    cell_cmd_t              cmd;
    logic [AW-1:0]          pos_a;
    logic [AW-1:0]          count_a;
    logic [AW-1:0]          ins_pos;
    logic [DATA_W-1:0]      cell_data  [CAPACITY];
    logic [DATA_W-1:0]      cell_rdata [CAPACITY];
    logic [DATA_W-1:0]      rd_bus;

    assign accept  = start && (state_reg == S_IDLE);
    assign pos_a   = AW'(position);
    assign count_a = AW'(count_reg);

    always_comb
    begin
        cmd        = '0;
        st_next    = ST_OK;
        count_next = count_reg;
        rd_ok_next = 1'b0;
        ins_pos    = pos_a;
        case (action)
            ACT_FRONT:  ins_pos = '0;
            ACT_BACK:   ins_pos = count_a;
            default:    ins_pos = pos_a;
        endcase
        case (action)
            ACT_READ:
            begin
                if (pos_a < count_a)
                begin
                    cmd.rd     = accept;
                    rd_ok_next = 1'b1;
                end
                else
                    st_next = ST_RANGE;
            end
            ACT_FRONT, ACT_BACK, ACT_AT:
            begin
                if (ins_pos > count_a)
                    st_next = ST_RANGE;
                else if (count_a >= CAP_A)
                    st_next = ST_FULL;
                else
                begin
                    cmd.ins    = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_DELETE:
            begin
                if (pos_a >= count_a)
                    st_next = ST_RANGE;
                else
                begin
                    cmd.del    = accept;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                st_next = ST_OK;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end
            ilid_cell #(
                .AW  (AW),
                .IDX (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .pos        (ins_pos),
                .value      (value),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .rdata      (cell_rdata[gi])
            );
        end
    endgenerate

    // At most one cell has its hit flag set, so the read bus is a plain OR.
    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_bus = rd_bus | cell_rdata[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            st_reg    <= ST_OK;
            rd_ok_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= S_RESP;
                        count_reg <= count_next;
                        st_reg    <= st_next;
                        rd_ok_reg <= rd_ok_next;
                    end
                end
                S_RESP:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RESP)
        begin
            read_value_reg  <= rd_ok_reg ? rd_bus : '1;
            status_reg      <= st_reg;
            entry_count_reg <= CNT_OUT_W'(count_reg);
        end
    end

    assign busy        = (state_reg == S_RESP);
    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

endmodule

### sv/ilid_cell.sv
// One slot of the list row. Shifts up on insert and down on delete by
// comparing its own index with the requested position. Depends on ilid_pkg.
module ilid_cell #(
    parameter int AW  = 7,
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ilid_pkg::cell_cmd_t         cmd,
    input  logic [AW-1:0]               pos,
    input  logic [ilid_pkg::DATA_W-1:0] value,
    input  logic [ilid_pkg::DATA_W-1:0] left_data,
    input  logic [ilid_pkg::DATA_W-1:0] right_data,
    output logic [ilid_pkg::DATA_W-1:0] data,
    output logic [ilid_pkg::DATA_W-1:0] rdata
);
    import ilid_pkg::*;

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit_reg;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (MY_IDX == pos)
                data_next = value;
            else if (MY_IDX > pos)
                data_next = left_data;
        end
        else if (cmd.del)
        begin
            if (MY_IDX >= pos)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // The hit flag selects this slot onto the read bus in the cycle after a read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else
            hit_reg <= cmd.rd && (MY_IDX == pos);
    end

    assign data  = data_reg;
    assign rdata = hit_reg ? data_reg : '0;

endmodule

### sv/ilid_checker.sv
// Port-level checks for the indexed list insert/delete unit, with its bind.
// Depends on ilid_pkg and on indexed_list_insert_delete_unit.
module ilid_checker #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           done,
    input  logic [ilid_pkg::DATA_W-1:0]    read_value,
    input  logic [1:0]                     status,
    input  logic [ilid_pkg::CNT_OUT_W-1:0] entry_count
);
    import ilid_pkg::*;

    // An accepted word always occupies the unit for exactly one cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not make the unit busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("busy cycle not followed by a result word");

    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a preceding busy cycle");

    // A failed action never carries read data.
    a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> read_value == '1)
        else $error("failed action returned read data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_FULL) |-> entry_count == CNT_OUT_W'(CAPACITY))
        else $error("full status with a list that is not full");

endmodule

bind indexed_list_insert_delete_unit ilid_checker #(
    .CAPACITY (CAPACITY)
) u_ilid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
);
